### hw/rtl/stc_pkg.sv
// shared types, constants and codes of the scaled time code converter
package stc_pkg;

  // default parameter values
  localparam int unsigned MaxFactorsDef  = 8;
  localparam int unsigned FactorWidthDef = 16;

  // fixed field widths
  localparam int unsigned CodeW     = 19;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CountW    = 4;
  localparam int unsigned MbitsW    = 5;
  localparam int unsigned MantW     = 16;
  localparam int unsigned FactorIdxW = 3;
  localparam int unsigned MbitsMax  = 16;

  // reset values of the configuration registers
  localparam logic [CfgDataW-1:0] FactorsLowRst  = 64'd28147712420085761;
  localparam logic [CfgDataW-1:0] FactorsHighRst = 64'd10133124931584000600;
  localparam logic [CountW-1:0]   FactorCountRst = 4'd8;
  localparam logic [MbitsW-1:0]   MbitsRst       = 5'd5;

  // request kinds
  localparam logic ReqDecode = 1'b0;
  localparam logic ReqEncode = 1'b1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FACTORS_LOW  = 2'd0,
    CFG_FACTORS_HIGH = 2'd1,
    CFG_FACTOR_COUNT = 2'd2,
    CFG_MBITS        = 2'd3
  } cfg_idx_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic             req_type;
    logic [CodeW-1:0] code_in;
    logic [TimeW-1:0] time_in;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0]   time_out;
    logic [CodeW-1:0]   code_out;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // effective configuration seen by the sequencer
  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [MbitsW-1:0] mb;
    logic [MantW-1:0]  maxm;
  } cfg_eff_t;

endpackage

### hw/rtl/stc_stream_if.sv
// valid/ready channel carrying one payload beat
interface stc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/scaled_time_code_converter.sv
// scaled time code converter: sequencer, shared multiplier and output register
// sequence: decode passes through DEC and LOAD; encode scans the factors in order
//   until factor k of 1..factor_count fits, the 33-step serial divider rounding it,
//   or ends the scan with a saturated mantissa when no factor fits
// throughput: one item at a time
// reset: asynchronous active low; config registers reload the default factors
module scaled_time_code_converter #(
  parameter int unsigned MAX_FACTORS  = stc_pkg::MaxFactorsDef,
  parameter int unsigned FACTOR_WIDTH = stc_pkg::FactorWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stc_stream_if.sink   req_i,
  stc_stream_if.source rsp_o,
  stc_stream_if.sink   cfg_i
);

  localparam int unsigned ProdW = stc_pkg::MantW + FACTOR_WIDTH;
  localparam int unsigned NumW  = stc_pkg::TimeW + 1;
  localparam int unsigned DenW  = FACTOR_WIDTH + 1;
  localparam int unsigned CW    = stc_pkg::CodeW;

  stc_pkg::state_e   state_q, state_d;
  stc_pkg::cfg_eff_t eff;

  logic [CW-1:0]                   code_q;
  logic [stc_pkg::TimeW-1:0]       time_q;
  logic [stc_pkg::FactorIdxW-1:0]  scan_q, scan_d, fidx;
  logic [FACTOR_WIDTH-1:0]         factor, fsave_q, fsave_d;
  stc_pkg::rsp_t                   res_q, res_d, out_q;
  logic                            out_valid_q;
  logic                            load;
  logic [stc_pkg::MantW-1:0]       mul_a;
  logic [ProdW-1:0]                prod;
  logic [CW-1:0]                   dec_idx, dec_mant;
  logic                            dec_oor, fit, scan_last;
  logic                            div_start, div_done;
  logic [NumW-1:0]                 div_num, div_quo;
  logic [DenW-1:0]                 div_den;
  logic [stc_pkg::MantW-1:0]       enc_mant;

  stc_cfg_regs #(
    .MAX_FACTORS (MAX_FACTORS),
    .FACTOR_WIDTH(FACTOR_WIDTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .fidx_i  (fidx),
    .factor_o(factor),
    .eff_o   (eff)
  );

  stc_divider #(
    .NUM_W(NumW),
    .DEN_W(DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // decode fields and the shared multiplier
  always_comb begin
    dec_idx   = code_q >> eff.mb;
    dec_mant  = code_q & CW'(eff.maxm);
    dec_oor   = dec_idx >= CW'(eff.cnt);
    fidx      = (state_q == stc_pkg::ST_DEC) ? dec_idx[stc_pkg::FactorIdxW-1:0] : scan_q;
    mul_a     = (state_q == stc_pkg::ST_DEC) ? dec_mant[stc_pkg::MantW-1:0] : eff.maxm;
    prod      = ProdW'(mul_a) * ProdW'(factor);
    fit       = {1'b0, time_q} <= NumW'(prod);
    scan_last = scan_q == stc_pkg::FactorIdxW'(eff.cnt - stc_pkg::CountW'(1));
    div_num   = {time_q, 1'b0} + NumW'(fsave_q);
    div_den   = {fsave_q, 1'b0};
    enc_mant  = (div_quo > NumW'(eff.maxm)) ? eff.maxm : div_quo[stc_pkg::MantW-1:0];
    load      = (state_q == stc_pkg::ST_LOAD) && (!out_valid_q || rsp_o.ready);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stc_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          state_d = (req_i.data.req_type == stc_pkg::ReqEncode) ? stc_pkg::ST_SCAN
                                                                : stc_pkg::ST_DEC;
        end
      end
      stc_pkg::ST_DEC:  state_d = stc_pkg::ST_LOAD;
      stc_pkg::ST_SCAN: begin
        if (fit) begin
          state_d = stc_pkg::ST_DIV_START;
        end else if (scan_last) begin
          state_d = stc_pkg::ST_LOAD;
        end
      end
      stc_pkg::ST_DIV_START: state_d = stc_pkg::ST_DIV;
      stc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = stc_pkg::ST_LOAD;
        end
      end
      stc_pkg::ST_LOAD: begin
        if (load) begin
          state_d = stc_pkg::ST_IDLE;
        end
      end
      default: state_d = stc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and result forming
  always_comb begin
    req_i.ready = (state_q == stc_pkg::ST_IDLE);
    div_start   = (state_q == stc_pkg::ST_DIV_START);
    scan_d      = scan_q;
    fsave_d     = fsave_q;
    res_d       = res_q;
    unique case (state_q)
      stc_pkg::ST_IDLE: begin
        scan_d = '0;
      end
      stc_pkg::ST_DEC: begin
        res_d.code_out = '0;
        if (dec_oor) begin
          res_d.time_out = '0;
          res_d.status   = stc_pkg::STAT_RANGE;
        end else begin
          res_d.time_out = stc_pkg::TimeW'(prod);
          res_d.status   = stc_pkg::STAT_OK;
        end
      end
      stc_pkg::ST_SCAN: begin
        res_d.time_out = '0;
        if (fit) begin
          fsave_d = factor;
        end else if (scan_last) begin
          res_d.code_out = (CW'(scan_q) << eff.mb) | CW'(eff.maxm);
          res_d.status   = stc_pkg::STAT_SAT;
        end else begin
          scan_d = scan_q + stc_pkg::FactorIdxW'(1);
        end
      end
      stc_pkg::ST_DIV: begin
        if (div_done) begin
          res_d.code_out = (CW'(scan_q) << eff.mb) | CW'(enc_mant);
          res_d.status   = stc_pkg::STAT_OK;
        end
      end
      stc_pkg::ST_DIV_START, stc_pkg::ST_LOAD: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      code_q     <= req_i.data.code_in;
      time_q     <= req_i.data.time_in;
    end
    fsave_q <= fsave_d;
    res_q   <= res_d;
    if (load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

### hw/rtl/stc_cfg_regs.sv
// configuration registers, effective count and width, factor lookup
module stc_cfg_regs #(
  parameter int unsigned MAX_FACTORS  = stc_pkg::MaxFactorsDef,
  parameter int unsigned FACTOR_WIDTH = stc_pkg::FactorWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  stc_stream_if.sink                          cfg_i,
  input  logic [stc_pkg::FactorIdxW-1:0]      fidx_i,
  output logic [FACTOR_WIDTH-1:0]             factor_o,
  output stc_pkg::cfg_eff_t                   eff_o
);

  logic [stc_pkg::CfgDataW-1:0] flow_q, fhigh_q;
  logic [stc_pkg::CountW-1:0]   fcnt_q;
  logic [stc_pkg::MbitsW-1:0]   mbits_q;
  logic [stc_pkg::CfgDataW-1:0] fsel;
  logic [FACTOR_WIDTH-1:0]      fraw;
  logic [stc_pkg::MbitsW-1:0]   mb_eff;
  logic [stc_pkg::MantW:0]      maxm_wide;

  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q  <= stc_pkg::FactorsLowRst;
      fhigh_q <= stc_pkg::FactorsHighRst;
      fcnt_q  <= stc_pkg::FactorCountRst;
      mbits_q <= stc_pkg::MbitsRst;
    end else if (cfg_i.valid) begin
      unique case (stc_pkg::cfg_idx_e'(cfg_i.data.index))
        stc_pkg::CFG_FACTORS_LOW:  flow_q  <= cfg_i.data.data;
        stc_pkg::CFG_FACTORS_HIGH: fhigh_q <= cfg_i.data.data;
        stc_pkg::CFG_FACTOR_COUNT: fcnt_q  <= cfg_i.data.data[stc_pkg::CountW-1:0];
        stc_pkg::CFG_MBITS:        mbits_q <= cfg_i.data.data[stc_pkg::MbitsW-1:0];
        default: ;
      endcase
    end
  end

  // factor lookup, a zero field counts as one
  always_comb begin
    fsel = fidx_i[2] ? fhigh_q : flow_q;
    fraw = fsel[fidx_i[1:0]*FACTOR_WIDTH +: FACTOR_WIDTH];
    factor_o = (fraw == '0) ? FACTOR_WIDTH'(1) : fraw;
  end

  // clamp count and mantissa width into their legal ranges
  always_comb begin
    if (fcnt_q == '0) begin
      eff_o.cnt = stc_pkg::CountW'(1);
    end else if (fcnt_q > stc_pkg::CountW'(MAX_FACTORS)) begin
      eff_o.cnt = stc_pkg::CountW'(MAX_FACTORS);
    end else begin
      eff_o.cnt = fcnt_q;
    end
    if (mbits_q == '0) begin
      mb_eff = stc_pkg::MbitsW'(1);
    end else if (mbits_q > stc_pkg::MbitsW'(stc_pkg::MbitsMax)) begin
      mb_eff = stc_pkg::MbitsW'(stc_pkg::MbitsMax);
    end else begin
      mb_eff = mbits_q;
    end
    eff_o.mb   = mb_eff;
    maxm_wide  = ((stc_pkg::MantW+1)'(1) << mb_eff) - (stc_pkg::MantW+1)'(1);
    eff_o.maxm = maxm_wide[stc_pkg::MantW-1:0];
  end

endmodule

### hw/rtl/stc_divider.sv
// restoring serial divider, one quotient bit per cycle
module stc_divider #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    rem_d   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_d   = {quo_q[NUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
